// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, skipped while reset is high.
`define LGI_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on the rising clock edge, reset included.
`define LGI_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/lgi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package lgi_pkg;
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_EVAL = 1'b1;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_COIN = 2'd1;
   localparam logic [1:0] STATUS_SAT  = 2'd2;

   // Bound on weights, terms and the running sum: 2^62 - 1.
   localparam logic [63:0] MAG_LIM = 64'h3FFF_FFFF_FFFF_FFFF;

   typedef logic [31:0] word_type;
endpackage
`default_nettype wire

// ----- rtl/lgi_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lgi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire  [$clog2(DEPTH)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]         wr_data,
   input  wire  [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ----- rtl/lgi_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Restoring radix-2 divider: (dividend << FRAC_BITS) / divisor, one quotient bit a cycle.
module lgi_div #(
   parameter int FRAC_BITS = 16
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   input  wire  [32:0]           dividend,
   input  wire  [32:0]           divisor,
   output logic                  done,
   output logic [33+FRAC_BITS-1:0] quot
);
   localparam int DW  = 33 + FRAC_BITS;
   localparam int CW  = $clog2(DW + 1);

   logic          busy_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic [33:0]   rem_ff;
   logic [DW-1:0] dvd_ff;
   logic [32:0]   dsr_ff;
   logic [33:0]   trial;
   logic          fits;

   assign trial = {rem_ff[32:0], dvd_ff[DW-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(DW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= {dividend, {FRAC_BITS{1'b0}}};
         dsr_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= fits ? trial - {1'b0, dsr_ff} : trial;
         dvd_ff <= {dvd_ff[DW-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quot = dvd_ff;
endmodule
`default_nettype wire

// ----- rtl/lgi_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Sign-magnitude trunc(a * b / 2^FRAC_BITS), four 32x32 partial products, saturated.
module lgi_mul #(
   parameter int FRAC_BITS = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   input  wire  [63:0] a_mag,
   input  wire  [63:0] b_mag,
   input  wire         neg,
   output logic        done,
   output logic [63:0] res_mag,
   output logic        res_neg,
   output logic        sat
);
   import lgi_pkg::*;

   logic         busy_ff;
   logic         done_ff;
   logic [2:0]   step_ff;
   logic [63:0]  a_ff;
   logic [63:0]  b_ff;
   logic         neg_ff;
   logic [127:0] prod_ff;
   logic [63:0]  res_mag_ff;
   logic         res_neg_ff;
   logic         sat_ff;
   logic [31:0]  ah;
   logic [31:0]  bh;
   logic [63:0]  part;
   logic [127:0] part_sh;
   logic [127:0] rsh;
   logic         over;
   logic [63:0]  rmag;

   assign ah   = step_ff[1] ? a_ff[63:32] : a_ff[31:0];
   assign bh   = step_ff[0] ? b_ff[63:32] : b_ff[31:0];
   assign part = ah * bh;

   always_comb begin
      case (step_ff) inside
         3'd0:       part_sh = {64'd0, part};
         3'd1, 3'd2: part_sh = {32'd0, part, 32'd0};
         default:    part_sh = {part, 64'd0};
      endcase
   end

   assign rsh  = prod_ff >> FRAC_BITS;
   assign over = rsh > {64'd0, MAG_LIM};
   assign rmag = over ? MAG_LIM : rsh[63:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            if (step_ff == 3'd4) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               step_ff <= step_ff + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff    <= a_mag;
         b_ff    <= b_mag;
         neg_ff  <= neg;
         prod_ff <= '0;
      end else if (busy_ff) begin
         if (step_ff == 3'd4) begin
            res_mag_ff <= rmag;
            res_neg_ff <= neg_ff && (rmag != 64'd0);
            sat_ff     <= over;
         end else begin
            prod_ff <= prod_ff + part_sh;
         end
      end
   end

   assign done    = done_ff;
   assign res_mag = res_mag_ff;
   assign res_neg = res_neg_ff;
   assign sat     = sat_ff;
endmodule
`default_nettype wire

// ----- rtl/lagrange_interpolator.sv -----
// Load request: taken while idle, and request ready stays high.
// Evaluate request: pairwise abscissa compares (a matching pair skips to the response),
// then for each node (n-1) factors, each a radix-2 divide and then a multiply, and a
// final multiply by the node ordinate; request ready stays low meanwhile.
// The divider and multiplier are shared by all nodes and factors. One request at a time.
// Reset: synchronous, active high; node_count goes to 1, node stores keep their contents.
`timescale 1ns / 1ps
`default_nettype none
module lagrange_interpolator #(
   parameter int MAX_NODES = 16,
   parameter int FRAC_BITS = 16
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  wire                req_func,
   input  wire  [3:0]         req_node_index,
   input  wire  signed [31:0] req_node_abscissa,
   input  wire  signed [31:0] req_node_ordinate,
   input  wire  signed [31:0] req_query_point,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic signed [31:0] rsp_interp_value,
   output logic [1:0]         rsp_status,
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire  [4:0]         csr_node_count
);
   import lgi_pkg::*;

   localparam int IDX_W = $clog2(MAX_NODES);
   localparam int CNT_W = $clog2(MAX_NODES + 1);
   localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
   localparam int DW    = 33 + FRAC_BITS;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CKI   = 4'd1;
   localparam logic [3:0] S_CKXI  = 4'd2;
   localparam logic [3:0] S_CKCMP = 4'd3;
   localparam logic [3:0] S_EVI   = 4'd4;
   localparam logic [3:0] S_EVXI  = 4'd5;
   localparam logic [3:0] S_EVJ   = 4'd6;
   localparam logic [3:0] S_EVXJ  = 4'd7;
   localparam logic [3:0] S_DIV   = 4'd8;
   localparam logic [3:0] S_WMUL  = 4'd9;
   localparam logic [3:0] S_TMUL  = 4'd10;
   localparam logic [3:0] S_OUT   = 4'd11;

   logic [3:0]        state_ff;
   logic [4:0]        node_count_ff;
   logic [CNT_W-1:0]  n_ff;
   logic [CNT_W-1:0]  i_ff;
   logic [CNT_W-1:0]  j_ff;
   logic [CNT_W-1:0]  i_nx;
   logic [CNT_W-1:0]  j_nx;
   word_type          q_ff;
   word_type          xi_ff;
   word_type          yi_ff;
   logic [63:0]       w_mag_ff;
   logic              w_neg_ff;
   logic              fneg_ff;
   logic signed [63:0] acc_ff;
   logic              sat_ff;
   logic              coin_ff;
   logic              rsp_valid_ff;
   word_type          rsp_value_ff;
   logic [1:0]        rsp_status_ff;

   logic [CMP_W-1:0]  nc_ext;
   logic [CNT_W-1:0]  n_use;
   logic [IDX_W-1:0]  rd_addr;
   word_type          x_rd;
   word_type          y_rd;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic              req_fire;
   logic              slot_free;

   logic [32:0]       num;
   logic [32:0]       den;
   logic [32:0]       num_mag;
   logic [32:0]       den_mag;
   logic              div_start;
   logic              div_done;
   logic [DW-1:0]     div_quot;

   logic              mul_start;
   logic [63:0]       mul_a;
   logic [63:0]       mul_b;
   logic              mul_neg;
   logic              mul_done;
   logic [63:0]       mul_mag;
   logic              mul_rneg;
   logic              mul_sat;
   logic [32:0]       y_mag;

   logic signed [64:0] term;
   logic signed [64:0] sum;
   logic signed [63:0] sum_sat;
   logic               sum_over;
   logic               out_over;
   word_type           out_val;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign nc_ext = CMP_W'(node_count_ff);
   always_comb begin
      if (nc_ext == '0) begin
         n_use = CNT_W'(1);
      end else if (nc_ext > CMP_W'(MAX_NODES)) begin
         n_use = CNT_W'(MAX_NODES);
      end else begin
         n_use = CNT_W'(nc_ext);
      end
   end

   assign wr_en   = req_fire && (req_func == FUNC_LOAD) &&
                    (32'(req_node_index) < MAX_NODES);
   assign wr_addr = IDX_W'(req_node_index);

   assign i_nx = i_ff + CNT_W'(1);
   assign j_nx = j_ff + CNT_W'(1);

   always_comb begin
      unique case (state_ff) inside
         S_CKI, S_EVI:  rd_addr = i_ff[IDX_W-1:0];
         S_CKXI, S_EVJ: rd_addr = j_ff[IDX_W-1:0];
         S_CKCMP:       rd_addr = j_nx[IDX_W-1:0];
         default:       rd_addr = '0;
      endcase
   end

   lgi_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_xram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_node_abscissa),
      .rd_addr (rd_addr),
      .rd_data (x_rd)
   );

   lgi_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_yram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_node_ordinate),
      .rd_addr (rd_addr),
      .rd_data (y_rd)
   );

   // Differences in 33 bits, taken apart into sign and magnitude.
   assign num     = {q_ff[31], q_ff} - {x_rd[31], x_rd};
   assign den     = {xi_ff[31], xi_ff} - {x_rd[31], x_rd};
   assign num_mag = num[32] ? 33'd0 - num : num;
   assign den_mag = den[32] ? 33'd0 - den : den;
   assign div_start = (state_ff == S_EVXJ);

   lgi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_mag),
      .divisor  (den_mag),
      .done     (div_done),
      .quot     (div_quot)
   );

   assign y_mag = yi_ff[31] ? 33'd0 - {1'b1, yi_ff} : {1'b0, yi_ff};

   always_comb begin
      mul_start = 1'b0;
      mul_a     = w_mag_ff;
      mul_b     = 64'(div_quot);
      mul_neg   = w_neg_ff ^ (fneg_ff && (div_quot != '0));
      if (state_ff == S_DIV && div_done) begin
         mul_start = 1'b1;
      end else if (state_ff == S_EVJ && j_ff == n_ff) begin
         mul_start = 1'b1;
         mul_a     = 64'(y_mag);
         mul_b     = w_mag_ff;
         mul_neg   = yi_ff[31] ^ w_neg_ff;
      end
   end

   lgi_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a_mag   (mul_a),
      .b_mag   (mul_b),
      .neg     (mul_neg),
      .done    (mul_done),
      .res_mag (mul_mag),
      .res_neg (mul_rneg),
      .sat     (mul_sat)
   );

   assign term = mul_rneg ? -$signed({1'b0, mul_mag}) : $signed({1'b0, mul_mag});
   assign sum  = {acc_ff[63], acc_ff} + term;
   always_comb begin
      sum_over = 1'b0;
      sum_sat  = sum[63:0];
      if (sum > $signed({1'b0, MAG_LIM})) begin
         sum_over = 1'b1;
         sum_sat  = $signed(MAG_LIM);
      end else if (sum < -$signed({1'b0, MAG_LIM})) begin
         sum_over = 1'b1;
         sum_sat  = -$signed(MAG_LIM);
      end
   end

   always_comb begin
      out_over = 1'b0;
      out_val  = acc_ff[31:0];
      if (acc_ff > 64'sd2147483647) begin
         out_over = 1'b1;
         out_val  = 32'h7FFF_FFFF;
      end else if (acc_ff < -64'sd2147483648) begin
         out_over = 1'b1;
         out_val  = 32'h8000_0000;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         node_count_ff <= 5'd1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            node_count_ff <= csr_node_count;
         end
         if (state_ff == S_OUT && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire && req_func == FUNC_EVAL) begin
                  state_ff <= S_CKI;
               end
            end
            S_CKI: begin
               if (i_nx >= n_ff) begin
                  state_ff <= S_EVI;
               end else begin
                  state_ff <= S_CKXI;
               end
            end
            S_CKXI: state_ff <= S_CKCMP;
            S_CKCMP: begin
               if (x_rd == xi_ff) begin
                  state_ff <= S_OUT;
               end else if (j_nx >= n_ff) begin
                  state_ff <= S_CKI;
               end
            end
            S_EVI:  state_ff <= S_EVXI;
            S_EVXI: state_ff <= S_EVJ;
            S_EVJ: begin
               if (j_ff == n_ff) begin
                  state_ff <= S_TMUL;
               end else if (j_ff != i_ff) begin
                  state_ff <= S_EVXJ;
               end
            end
            S_EVXJ: state_ff <= S_DIV;
            S_DIV: begin
               if (div_done) begin
                  state_ff <= S_WMUL;
               end
            end
            S_WMUL: begin
               if (mul_done) begin
                  state_ff <= S_EVJ;
               end
            end
            S_TMUL: begin
               if (mul_done) begin
                  state_ff <= (i_nx == n_ff) ? S_OUT : S_EVI;
               end
            end
            S_OUT: begin
               if (slot_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && req_func == FUNC_EVAL) begin
               q_ff    <= req_query_point;
               n_ff    <= n_use;
               i_ff    <= '0;
               acc_ff  <= '0;
               sat_ff  <= 1'b0;
               coin_ff <= 1'b0;
            end
         end
         S_CKI: begin
            if (i_nx >= n_ff) begin
               i_ff <= '0;
            end else begin
               j_ff <= i_nx;
            end
         end
         S_CKXI: xi_ff <= x_rd;
         S_CKCMP: begin
            if (x_rd == xi_ff) begin
               coin_ff <= 1'b1;
            end else if (j_nx >= n_ff) begin
               i_ff <= i_nx;
            end else begin
               j_ff <= j_nx;
            end
         end
         S_EVI: begin
            j_ff     <= '0;
            w_mag_ff <= 64'd1 << FRAC_BITS;
            w_neg_ff <= 1'b0;
         end
         S_EVXI: begin
            xi_ff <= x_rd;
            yi_ff <= y_rd;
         end
         S_EVJ: begin
            if (j_ff != n_ff && j_ff == i_ff) begin
               j_ff <= j_nx;
            end
         end
         S_EVXJ: fneg_ff <= num[32] ^ den[32];
         S_DIV: ;
         S_WMUL: begin
            if (mul_done) begin
               w_mag_ff <= mul_mag;
               w_neg_ff <= mul_rneg;
               sat_ff   <= sat_ff | mul_sat;
               j_ff     <= j_nx;
            end
         end
         S_TMUL: begin
            if (mul_done) begin
               acc_ff <= sum_sat;
               sat_ff <= sat_ff | mul_sat | sum_over;
               i_ff   <= i_nx;
            end
         end
         S_OUT: begin
            if (slot_free) begin
               if (coin_ff) begin
                  rsp_value_ff  <= '0;
                  rsp_status_ff <= STATUS_COIN;
               end else begin
                  rsp_value_ff  <= out_val;
                  rsp_status_ff <= (sat_ff || out_over) ? STATUS_SAT : STATUS_OK;
               end
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_interp_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
endmodule
`default_nettype wire

// ----- rtl/lgi_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lgi_checker (
   input wire               clock,
   input wire               reset,
   input wire               req_valid,
   input wire               req_ready,
   input wire               req_func,
   input wire               rsp_valid,
   input wire               rsp_ready,
   input wire signed [31:0] rsp_interp_value,
   input wire        [1:0]  rsp_status
);
   import lgi_pkg::*;

   `LGI_ASSERT(a_status_code, rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_COIN || rsp_status == STATUS_SAT), "unknown response status")
   `LGI_ASSERT(a_coin_zero, (rsp_valid && rsp_status == STATUS_COIN) |-> (rsp_interp_value == 32'sd0), "coincident response carries a value")
   `LGI_ASSERT(a_eval_busy, (req_valid && req_ready && req_func == FUNC_EVAL) |=> !req_ready, "ready after evaluate request")
   `LGI_ASSERT_ALWAYS(a_rsp_hold, (!reset && rsp_valid && !rsp_ready) |=> (reset || (rsp_valid && $stable(rsp_interp_value) && $stable(rsp_status))), "stalled response changed")
endmodule

bind lagrange_interpolator lgi_checker u_lgi_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_func         (req_func),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_interp_value (rsp_interp_value),
   .rsp_status       (rsp_status)
);
`default_nettype wire
